// ===== hdl/sorted_key_table_insert_lookup_assert.svh =====
// ----------------------------------------------------------------------------
// sorted key table assertion macros
// concurrent assertion helpers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef SORTED_KEY_TABLE_INSERT_LOOKUP_ASSERT_SVH
`define SORTED_KEY_TABLE_INSERT_LOOKUP_ASSERT_SVH

`ifndef SYNTH

// same-cycle implication, disabled during reset
`define SKT_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sorted key table assertion failed");

// next-cycle implication, disabled during reset
`define SKT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sorted key table assertion failed");

`else

`define SKT_ASSERT_IMPL(label, ante, cons)
`define SKT_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== hdl/skt_pkg.sv =====
// ----------------------------------------------------------------------------
// skt_pkg
// field widths and codes shared by the sorted key table files
// ----------------------------------------------------------------------------
`default_nettype none

package skt_pkg;

  localparam int KEY_W    = 16;
  localparam int LEVEL_W  = 8;
  localparam int STATUS_W = 3;
  localparam int OUT_W    = 5;
  localparam int ENTRY_W  = KEY_W + LEVEL_W;

  // request kinds
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  // response status codes
  localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_UPDATED  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DROPPED  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_HIT      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_MISS     = 3'd4;

endpackage

`default_nettype wire

// ===== hdl/skt_req_if.sv =====
// ----------------------------------------------------------------------------
// skt_req_if
// request channel: insert or lookup transaction with valid/ready
// ----------------------------------------------------------------------------
`default_nettype none

interface skt_req_if;
  logic                                valid;
  logic                                ready;
  logic                                kind;
  logic signed [skt_pkg::KEY_W-1:0]    key_id;
  logic        [skt_pkg::LEVEL_W-1:0]  level_in;

  modport source (output valid, output kind, output key_id, output level_in,
                  input ready);
  modport sink   (input valid, input kind, input key_id, input level_in,
                  output ready);
endinterface

`default_nettype wire

// ===== hdl/skt_rsp_if.sv =====
// ----------------------------------------------------------------------------
// skt_rsp_if
// response channel: status, slot, level and entry count with valid/ready
// ----------------------------------------------------------------------------
`default_nettype none

interface skt_rsp_if;
  logic                                valid;
  logic                                ready;
  logic [skt_pkg::STATUS_W-1:0]        status;
  logic [skt_pkg::OUT_W-1:0]           slot;
  logic [skt_pkg::LEVEL_W-1:0]         level_out;
  logic [skt_pkg::OUT_W-1:0]           entry_count;

  modport source (output valid, output status, output slot, output level_out,
                  output entry_count, input ready);
  modport sink   (input valid, input status, input slot, input level_out,
                  input entry_count, output ready);
endinterface

`default_nettype wire

// ===== hdl/sorted_key_table_insert_lookup.sv =====
// sequence: accept, then a linear scan of one entry per cycle up to the key's place,
//   a decide step, then for an insert that lands below the top a shift of each entry
//   above it and a place step, and last a load of the response register
// flow: one transaction at a time; a new one is taken only once the last has been
//   loaded into the response register, which waits on response stalls
// reset: entry count and handshake state clear; the entry memory keeps its contents
// ----------------------------------------------------------------------------
// sorted_key_table_insert_lookup
// sorted (key, level) table held in one synchronous memory with insert/update
// and lookup, served by a scan / shift sequencer
// ----------------------------------------------------------------------------
`default_nettype none

`include "sorted_key_table_insert_lookup_assert.svh"

module sorted_key_table_insert_lookup #(
  parameter int TABLE_DEPTH = 16
) (
  input  wire        clk,
  input  wire        rst,
  skt_req_if.sink    req,
  skt_rsp_if.source  rsp
);
  import skt_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_SHIFT,
    S_PLACE,
    S_FINISH
  } state_t;

  state_t state;

  // entry memory: {key, level}, one write and one registered read per cycle
  logic [ENTRY_W-1:0] mem [TABLE_DEPTH];
  logic [ENTRY_W-1:0] rd_data;
  logic [AW-1:0]      rd_addr;
  logic               mem_we;
  logic [AW-1:0]      wr_addr;
  logic [ENTRY_W-1:0] wr_data;

  // transaction held while it is worked on
  logic                     kind;
  logic signed [KEY_W-1:0]  key;
  logic [LEVEL_W-1:0]       level;

  logic [CW-1:0]      count;     // valid entries, slots 0 .. count-1
  logic [AW-1:0]      idx;       // scan position
  logic [AW-1:0]      sidx;      // shift destination slot
  logic [CW-1:0]      pos;       // lower-bound position of the key
  logic               hit;
  logic [LEVEL_W-1:0] hit_level;

  // response waiting for the output register
  logic [STATUS_W-1:0] res_status;
  logic [CW-1:0]       res_slot;
  logic [LEVEL_W-1:0]  res_level;

  // output register
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [OUT_W-1:0]    out_slot;
  logic [LEVEL_W-1:0]  out_level;
  logic [OUT_W-1:0]    out_count;

  logic signed [KEY_W-1:0] rd_key;
  logic                    full;
  logic                    key_below;

  assign rd_key    = rd_data[ENTRY_W-1:LEVEL_W];
  assign full      = (count == CW'(TABLE_DEPTH));
  assign key_below = (rd_key < key);

  assign req.ready       = (state == S_IDLE);
  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.slot        = out_slot;
  assign rsp.level_out   = out_level;
  assign rsp.entry_count = out_count;

  // memory port control
  always_comb begin
    rd_addr = '0;
    mem_we  = 1'b0;
    wr_addr = pos[AW-1:0];
    wr_data = {key, level};
    unique case (state)
      S_IDLE:   rd_addr = '0;
      S_SCAN:   rd_addr = idx + 1'b1;
      S_DECIDE: begin
        // prefetch the top entry for a shift
        rd_addr = count[AW-1:0] - 1'b1;
        if (kind == KIND_INSERT) begin
          // update in place, or append at the top
          if (hit || (!full && pos == count)) begin
            mem_we = 1'b1;
          end
        end
      end
      S_SHIFT: begin
        rd_addr = sidx - AW'(2);
        mem_we  = 1'b1;
        wr_addr = sidx;
        wr_data = rd_data;
      end
      S_PLACE:  mem_we = 1'b1;
      S_FINISH: rd_addr = '0;
      default:  rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      // load a new response, or retire the one taken this cycle
      if (state == S_FINISH && (!out_valid || rsp.ready)) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            kind  <= req.kind;
            key   <= req.key_id;
            level <= req.level_in;
            idx   <= '0;
            if (count == '0) begin
              // empty table: nothing to scan
              pos   <= '0;
              hit   <= 1'b0;
              state <= S_DECIDE;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // rd_data holds entry idx
          if (key_below) begin
            if (CW'(idx) + 1'b1 < count) begin
              idx <= idx + 1'b1;
            end else begin
              pos   <= count;
              hit   <= 1'b0;
              state <= S_DECIDE;
            end
          end else begin
            pos       <= CW'(idx);
            hit       <= (rd_key == key);
            hit_level <= rd_data[LEVEL_W-1:0];
            state     <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          res_level <= '0;
          res_slot  <= pos;
          state     <= S_FINISH;
          if (kind == KIND_LOOKUP) begin
            res_status <= hit ? ST_HIT : ST_MISS;
            res_slot   <= hit ? pos : count;
            res_level  <= hit ? hit_level : '0;
          end else if (hit) begin
            res_status <= ST_UPDATED;
          end else if (full) begin
            res_status <= ST_DROPPED;
            res_slot   <= count;
          end else if (pos == count) begin
            res_status <= ST_INSERTED;
            count      <= count + 1'b1;
          end else begin
            res_status <= ST_INSERTED;
            sidx       <= count[AW-1:0];
            state      <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          // entry sidx-1 moves up to sidx this cycle
          if (CW'(sidx - 1'b1) == pos) begin
            state <= S_PLACE;
          end else begin
            sidx <= sidx - 1'b1;
          end
        end
        S_PLACE: begin
          count <= count + 1'b1;
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (!out_valid || rsp.ready) begin
            out_status <= res_status;
            out_slot   <= OUT_W'(res_slot);
            out_level  <= res_level;
            out_count  <= OUT_W'(count);
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // the count never passes the depth and grows by at most one per cycle
  `SKT_ASSERT_IMPL(a_count_bound, 1'b1, count <= CW'(TABLE_DEPTH))
  `SKT_ASSERT_IMPL(a_count_step, count != $past(count), count == CW'($past(count) + 1'b1))
  // no memory write while taking a transaction or scanning
  `SKT_ASSERT_IMPL(a_no_write_scan, state == S_IDLE || state == S_SCAN, !mem_we)
  // the new entry is placed after its shift, then the response follows
  `SKT_ASSERT_NEXT(a_place_finish, state == S_PLACE, state == S_FINISH)

endmodule

`default_nettype wire

// ===== verif/sorted_key_table_insert_lookup_tb.sv =====
// ----------------------------------------------------------------------------
// sorted_key_table_insert_lookup_tb
// drives insert and lookup transactions with random gaps and stalls, keeps a
// sorted shadow table of its own and checks every response field by field
// ----------------------------------------------------------------------------
module sorted_key_table_insert_lookup_tb;
  import skt_pkg::*;

  localparam int DEPTH          = 16;
  localparam int RANDOM_OPS     = 750;
  localparam int TAIL_OPS       = 80;    // last transactions run with no gaps or stalls
  localparam int SETTLE_CYCLES  = 2 * DEPTH + 8;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic                        kind;
    logic signed [KEY_W-1:0]     key_id;
    logic        [LEVEL_W-1:0]   level_in;
  } table_op_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [OUT_W-1:0]    slot;
    logic [LEVEL_W-1:0]  level_out;
    logic [OUT_W-1:0]    entry_count;
  } table_reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  skt_req_if req_bus ();
  skt_rsp_if rsp_bus ();

  sorted_key_table_insert_lookup #(
    .TABLE_DEPTH (DEPTH)
  ) u_top (
    .clk (clk),
    .rst (rst),
    .req (req_bus),
    .rsp (rsp_bus)
  );

  always #6 clk = ~clk;

  // known values on every input before the first edge
  initial begin
    req_bus.valid    = 1'b0;
    req_bus.kind     = KIND_INSERT;
    req_bus.key_id   = '0;
    req_bus.level_in = '0;
    rsp_bus.ready    = 1'b0;
  end

  // stimulus waiting for the driver, replies waiting for the monitor
  table_op_t    pending_ops[$];
  table_reply_t awaited_replies[$];
  bit           all_queued = 1'b0;
  int           mismatches = 0;

  // keys the stimulus has already placed in the table, used to aim hits and updates
  logic signed [KEY_W-1:0] placed_keys[$];

  // shadow of the block's table, updated in the order transactions are accepted
  logic signed [KEY_W-1:0] shadow_keys[DEPTH];
  logic [LEVEL_W-1:0]      shadow_levels[DEPTH];
  int unsigned             shadow_count = 0;

  task automatic flag_error(input string what);
    $display("mismatch at %0t: %s", $time, what);
    mismatches++;
  endtask

  // lower-bound search, then lookup, update, drop or shifting insert
  function automatic table_reply_t apply_table_op(input table_op_t op);
    logic signed [KEY_W-1:0] k;
    int unsigned             pos;
    bit                      found;
    table_reply_t            r;
    k   = op.key_id;
    pos = 0;
    while (pos < shadow_count && shadow_keys[pos] < k) pos++;
    found = (pos < shadow_count) && (shadow_keys[pos] == k);
    r = '0;
    if (op.kind == KIND_LOOKUP) begin
      if (found) begin
        r.status    = ST_HIT;
        r.slot      = OUT_W'(pos);
        r.level_out = shadow_levels[pos];
      end else begin
        r.status = ST_MISS;
        r.slot   = OUT_W'(shadow_count);
      end
    end else if (found) begin
      shadow_levels[pos] = op.level_in;
      r.status = ST_UPDATED;
      r.slot   = OUT_W'(pos);
    end else if (shadow_count >= DEPTH) begin
      r.status = ST_DROPPED;
      r.slot   = OUT_W'(shadow_count);
    end else begin
      for (int i = shadow_count; i > pos; i--) begin
        shadow_keys[i]   = shadow_keys[i-1];
        shadow_levels[i] = shadow_levels[i-1];
      end
      shadow_keys[pos]   = k;
      shadow_levels[pos] = op.level_in;
      shadow_count++;
      r.status = ST_INSERTED;
      r.slot   = OUT_W'(pos);
    end
    r.entry_count = OUT_W'(shadow_count);
    return r;
  endfunction

  function automatic bit key_placed(input logic signed [KEY_W-1:0] k);
    foreach (placed_keys[i]) if (placed_keys[i] == k) return 1'b1;
    return 1'b0;
  endfunction

  // an absent key: either fully random or right next to a present one
  function automatic logic signed [KEY_W-1:0] novel_key();
    logic signed [KEY_W-1:0] k;
    do begin
      if (placed_keys.size() != 0 && $urandom_range(0, 1))
        k = placed_keys[$urandom_range(0, placed_keys.size() - 1)] +
            ($urandom_range(0, 1) ? 16'sd1 : -16'sd1);
      else
        k = KEY_W'($urandom_range(0, 65535));
    end while (key_placed(k));
    return k;
  endfunction

  function automatic logic signed [KEY_W-1:0] present_key();
    return placed_keys[$urandom_range(0, placed_keys.size() - 1)];
  endfunction

  task automatic queue_op(input logic kind, input logic signed [KEY_W-1:0] k,
                          input logic [LEVEL_W-1:0] lvl);
    table_op_t op;
    op.kind     = kind;
    op.key_id   = k;
    op.level_in = lvl;
    if (kind == KIND_INSERT && !key_placed(k) && placed_keys.size() < DEPTH)
      placed_keys.push_back(k);
    pending_ops.push_back(op);
  endtask

  // wait until every queued transaction is sent and answered,
  // checked between edges so that the driver and monitor have settled
  task automatic drain_table_ops();
    while (pending_ops.size() != 0 || req_bus.valid || awaited_replies.size() != 0)
      @(negedge clk);
  endtask

  function automatic bit calm_tail();
    return all_queued && pending_ops.size() < TAIL_OPS;
  endfunction

  // stimulus and end of test
  initial begin
    int unsigned roll;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: empty table, key extremes, update, hits and misses around entries
    queue_op(KIND_LOOKUP, 16'sd0, 8'h00);
    queue_op(KIND_INSERT, -16'sd32768, 8'hFF);
    queue_op(KIND_INSERT, 16'sd32767, 8'h00);
    queue_op(KIND_INSERT, 16'sd0, 8'h5A);
    queue_op(KIND_INSERT, 16'sd0, 8'hA5);
    queue_op(KIND_LOOKUP, -16'sd32768, 8'h00);
    queue_op(KIND_LOOKUP, 16'sd32767, 8'h00);
    queue_op(KIND_LOOKUP, -16'sd1, 8'h00);
    queue_op(KIND_LOOKUP, 16'sd1, 8'h00);
    queue_op(KIND_INSERT, -16'sd1, 8'h3C);
    queue_op(KIND_INSERT, -16'sd32767, 8'hC3);
    // level on a lookup is ignored
    queue_op(KIND_LOOKUP, 16'sd0, 8'hFF);
    // fill the rest with keys landing at random places, shifting entries up
    while (placed_keys.size() < DEPTH)
      queue_op(KIND_INSERT, novel_key(), LEVEL_W'($urandom_range(0, 255)));
    // full table: new key dropped, present key still updated, lookups unaffected
    queue_op(KIND_INSERT, novel_key(), LEVEL_W'($urandom_range(0, 255)));
    queue_op(KIND_INSERT, placed_keys[3], LEVEL_W'($urandom_range(0, 255)));
    queue_op(KIND_LOOKUP, placed_keys[3], 8'h00);
    queue_op(KIND_LOOKUP, novel_key(), 8'h00);

    // hold off until the directed transactions are all answered
    drain_table_ops();

    // random: mostly hits and updates on present keys, some misses and drops
    repeat (RANDOM_OPS) begin
      roll = $urandom_range(0, 99);
      if (roll < 35)
        queue_op(KIND_LOOKUP, present_key(), LEVEL_W'($urandom_range(0, 255)));
      else if (roll < 60)
        queue_op(KIND_INSERT, present_key(), LEVEL_W'($urandom_range(0, 255)));
      else if (roll < 75)
        queue_op(KIND_INSERT, novel_key(), LEVEL_W'($urandom_range(0, 255)));
      else
        queue_op(KIND_LOOKUP, novel_key(), LEVEL_W'($urandom_range(0, 255)));
    end
    all_queued = 1'b1;

    drain_table_ops();
    // let any stray response show up before closing
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && awaited_replies.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // driver: presents queued transactions, idles in random bursts,
  // predicts the reply at the edge that accepts the transaction
  int unsigned send_idle = 0;

  always @(posedge clk) begin
    table_op_t op;
    if (rst) begin
      req_bus.valid <= 1'b0;
      send_idle = 0;
    end else begin
      if (req_bus.valid && req_bus.ready) begin
        op.kind     = req_bus.kind;
        op.key_id   = req_bus.key_id;
        op.level_in = req_bus.level_in;
        awaited_replies.push_back(apply_table_op(op));
      end
      // fields stay put while a transaction waits for ready
      if (!req_bus.valid || req_bus.ready) begin
        if (send_idle > 0) begin
          send_idle--;
          req_bus.valid <= 1'b0;
        end else if (pending_ops.size() != 0 && !calm_tail() &&
                     $urandom_range(0, 5) == 0) begin
          send_idle = $urandom_range(1, 14) - 1;
          req_bus.valid <= 1'b0;
        end else if (pending_ops.size() != 0) begin
          op = pending_ops.pop_front();
          req_bus.valid    <= 1'b1;
          req_bus.kind     <= op.kind;
          req_bus.key_id   <= op.key_id;
          req_bus.level_in <= op.level_in;
        end else begin
          req_bus.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: stalls ready in random bursts, checks each accepted response
  int unsigned stall_left = 0;

  always @(posedge clk) begin
    table_reply_t want;
    if (rst) begin
      rsp_bus.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        if (awaited_replies.size() == 0) begin
          flag_error($sformatf("response with none pending: status %0d slot %0d",
                               rsp_bus.status, rsp_bus.slot));
        end else begin
          want = awaited_replies.pop_front();
          if (rsp_bus.status !== want.status)
            flag_error($sformatf("status %0d, want %0d", rsp_bus.status, want.status));
          if (rsp_bus.slot !== want.slot)
            flag_error($sformatf("slot %0d, want %0d", rsp_bus.slot, want.slot));
          if (rsp_bus.level_out !== want.level_out)
            flag_error($sformatf("level_out %0d, want %0d",
                                 rsp_bus.level_out, want.level_out));
          if (rsp_bus.entry_count !== want.entry_count)
            flag_error($sformatf("entry_count %0d, want %0d",
                                 rsp_bus.entry_count, want.entry_count));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp_bus.ready <= 1'b0;
      end else if (!calm_tail() && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 14) - 1;
        rsp_bus.ready <= 1'b0;
      end else begin
        rsp_bus.ready <= 1'b1;
      end
    end
  end

  // watchdog: too long with no transaction on either channel
  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
